// File: sv/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
package bmhq_pkg;

  // Capacity register width and reset value.
  localparam int unsigned CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Status code width.
  localparam int unsigned STAT_W = 2;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELMIN = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Heap memory strobes from the sequencer.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: sv/bmhq_mem.sv
// Heap key storage: one write port, one read port, registered read data.
module bmhq_mem #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  bmhq_pkg::mem_ctl_t     ctl,
  input  logic [AW-1:0]          waddr,
  input  logic [DATA_WIDTH-1:0]  wdata,
  input  logic [AW-1:0]          raddr,
  output logic [DATA_WIDTH-1:0]  rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/binary_min_heap_queue_core.sv
// Binary min-heap priority queue: sequencer, shared key comparator and heap memory.
//
// Usage: drive in_func/in_value and raise start while busy is low; the transaction
// is taken at that clock edge. One result per transaction appears on the out_*
// ports for exactly one cycle, marked by out_valid; the receiver cannot stall it.
// cfg_capacity is written when cfg_valid and cfg_ready are high (cfg_ready is
// always high); write it only while the core is idle.
// Steps from accept to out_valid (the key moves at most log2(DEPTH) levels):
//   clear, refused insert, empty delete/peek: no memory read
//   peek: root read (delete-min reads the root, then the last key)
//   insert: per level one parent read and one compare
//   delete-min: per level left read, right read, child select, move compare
// All key reads go through the single read port of the heap memory and all
// compares through one signed comparator; one transaction is worked at a time.
// A new start is taken in the cycle out_valid is shown.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 1024.
// Memory contents are not cleared; only slots below the count are ever read.
module binary_min_heap_queue_core #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic signed [DATA_WIDTH-1:0]  in_value,
  output logic                          out_valid,
  output logic signed [DATA_WIDTH-1:0]  out_data,
  output logic [bmhq_pkg::STAT_W-1:0]   out_status,
  output logic [$clog2(DEPTH+1)-1:0]    out_count,
  output logic                          out_is_full,
  output logic                          out_is_empty,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmhq_pkg::CAP_W-1:0]    cfg_capacity
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MW    = (CNT_W > bmhq_pkg::CAP_W) ? CNT_W : bmhq_pkg::CAP_W;
  localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);
  localparam logic [DATA_WIDTH-1:0] SENTINEL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_INS_UP   = 10'b0000000010,
    S_INS_CMP  = 10'b0000000100,
    S_DEL_ROOT = 10'b0000001000,
    S_DEL_LAST = 10'b0000010000,
    S_DEL_DOWN = 10'b0000100000,
    S_DEL_L    = 10'b0001000000,
    S_DEL_R    = 10'b0010000000,
    S_DEL_CMP  = 10'b0100000000,
    S_PEEK     = 10'b1000000000
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [CNT_W-1:0] pos);
    logic [CNT_W-1:0] t;
    t = pos - CNT_W'(1);
    return t[AW-1:0];
  endfunction

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CNT_W-1:0]                idx_r, idx_nxt;
  logic [CNT_W-1:0]                chi_r, chi_nxt;
  logic [DATA_WIDTH-1:0]           key_r, key_nxt;
  logic [DATA_WIDTH-1:0]           top_r, top_nxt;
  logic [DATA_WIDTH-1:0]           child_r, child_nxt;
  logic [bmhq_pkg::CAP_W-1:0]      cap_r;
  logic                            out_valid_r;
  logic [DATA_WIDTH-1:0]           out_data_r;
  logic [bmhq_pkg::STAT_W-1:0]     out_status_r;
  logic [CNT_W-1:0]                out_count_r;
  logic                            out_full_r;
  logic                            out_empty_r;

  logic                            fin;
  logic [DATA_WIDTH-1:0]           res_data;
  logic [bmhq_pkg::STAT_W-1:0]     res_status;
  bmhq_pkg::mem_ctl_t              mem_ctl;
  logic [AW-1:0]                   waddr, raddr;
  logic [DATA_WIDTH-1:0]           wdata, rd_data;
  logic [DATA_WIDTH-1:0]           cmp_a, cmp_b;
  logic                            cmp_gt;
  logic [MW-1:0]                   cap_eff, cnt_m, cnt_nxt_m;
  logic [CNT_W:0]                  c_wide, n_wide;
  logic [CNT_W-1:0]                c_pos;

  assign cap_eff = (MW'(cap_r) > DEPTH_M) ? DEPTH_M : MW'(cap_r);
  assign cnt_m   = MW'(count_r);
  assign cnt_nxt_m = MW'(count_nxt);
  assign c_wide  = {idx_r, 1'b0};
  assign n_wide  = {1'b0, count_r};
  assign c_pos   = c_wide[CNT_W-1:0];

  // Shared signed comparator, operands picked by state.
  always_comb begin
    cmp_a = rd_data;
    cmp_b = key_r;
    case (state_r)
      S_DEL_R: begin
        cmp_a = rd_data;
        cmp_b = child_r;
      end
      S_DEL_CMP: begin
        cmp_a = key_r;
        cmp_b = child_r;
      end
      default: begin
        cmp_a = rd_data;
        cmp_b = key_r;
      end
    endcase
  end

  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    chi_nxt    = chi_r;
    key_nxt    = key_r;
    top_nxt    = top_r;
    child_nxt  = child_r;
    fin        = 1'b0;
    res_data   = '0;
    res_status = bmhq_pkg::ST_OK;
    mem_ctl    = '0;
    raddr      = '0;
    waddr      = addr_of(idx_r);
    wdata      = key_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (bmhq_pkg::func_t'(in_func))
            bmhq_pkg::FUNC_INSERT: begin
              if (cnt_m >= cap_eff) begin
                fin        = 1'b1;
                res_status = bmhq_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                idx_nxt   = count_r + CNT_W'(1);
                key_nxt   = in_value;
                state_nxt = S_INS_UP;
              end
            end
            bmhq_pkg::FUNC_DELMIN, bmhq_pkg::FUNC_PEEK: begin
              if (count_r == '0) begin
                fin        = 1'b1;
                res_data   = SENTINEL;
                res_status = bmhq_pkg::ST_EMPTY;
              end else begin
                mem_ctl.re = 1'b1;
                raddr      = '0;
                state_nxt  = (in_func == bmhq_pkg::FUNC_PEEK) ? S_PEEK : S_DEL_ROOT;
              end
            end
            bmhq_pkg::FUNC_CLEAR: begin
              fin       = 1'b1;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_PEEK: begin
        fin      = 1'b1;
        res_data = rd_data;
        state_nxt = S_IDLE;
      end
      S_INS_UP: begin
        if (idx_r == CNT_W'(1)) begin
          mem_ctl.we = 1'b1;
          fin        = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          mem_ctl.re = 1'b1;
          raddr      = addr_of(idx_r >> 1);
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_ctl.we = 1'b1;
        if (cmp_gt) begin
          // parent larger: move it down one level
          wdata     = rd_data;
          idx_nxt   = idx_r >> 1;
          state_nxt = S_INS_UP;
        end else begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DEL_ROOT: begin
        top_nxt    = rd_data;
        mem_ctl.re = 1'b1;
        raddr      = addr_of(count_r);
        state_nxt  = S_DEL_LAST;
      end
      S_DEL_LAST: begin
        key_nxt   = rd_data;
        count_nxt = count_r - CNT_W'(1);
        idx_nxt   = CNT_W'(1);
        state_nxt = S_DEL_DOWN;
      end
      S_DEL_DOWN: begin
        if (c_wide > n_wide) begin
          mem_ctl.we = 1'b1;
          fin        = 1'b1;
          res_data   = top_r;
          state_nxt  = S_IDLE;
        end else begin
          mem_ctl.re = 1'b1;
          raddr      = addr_of(c_pos);
          state_nxt  = S_DEL_L;
        end
      end
      S_DEL_L: begin
        child_nxt = rd_data;
        chi_nxt   = c_pos;
        if (c_wide != n_wide) begin
          mem_ctl.re = 1'b1;
          raddr      = addr_of(c_pos + CNT_W'(1));
          state_nxt  = S_DEL_R;
        end else begin
          state_nxt = S_DEL_CMP;
        end
      end
      S_DEL_R: begin
        // right child wins ties
        if (!cmp_gt) begin
          child_nxt = rd_data;
          chi_nxt   = chi_r + CNT_W'(1);
        end
        state_nxt = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        mem_ctl.we = 1'b1;
        if (cmp_gt) begin
          wdata     = child_r;
          idx_nxt   = chi_r;
          state_nxt = S_DEL_DOWN;
        end else begin
          fin       = 1'b1;
          res_data  = top_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= bmhq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    chi_r   <= chi_nxt;
    key_r   <= key_nxt;
    top_r   <= top_nxt;
    child_r <= child_nxt;
    if (fin) begin
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_count_r  <= count_nxt;
      out_full_r   <= (cnt_nxt_m >= cap_eff);
      out_empty_r  <= (count_nxt == '0);
    end
  end

  bmhq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_full  = out_full_r;
  assign out_is_empty = out_empty_r;

  // Entry count never passes the storage depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("heap count exceeds depth");

  // An accepted transaction either finishes next cycle or keeps the core busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction dropped");

  // A refused insert only happens when the queue reports full.
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bmhq_pkg::ST_FULL) |-> out_is_full)
    else $error("insert refused while not full");

  // Empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag mismatch");

endmodule

// File: tb/sv/heap_queue_scoreboard_pkg.sv
// Scoreboard for the min-heap queue: shadow heap, expected results and result checks.
package heap_queue_scoreboard_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned COUNT_W = $clog2(HEAP_DEPTH + 1);
  localparam logic signed [KEY_W-1:0] KEY_SENTINEL = {1'b1, {(KEY_W-1){1'b0}}};

  typedef struct {
    logic signed [KEY_W-1:0]       data;
    logic [bmhq_pkg::STAT_W-1:0]   status;
    logic [COUNT_W-1:0]            count;
    logic                          is_full;
    logic                          is_empty;
  } heap_result_t;

  class heap_queue_scoreboard;
    logic signed [KEY_W-1:0] keys [1:HEAP_DEPTH];
    int unsigned             n_entries;
    int unsigned             capacity;
    heap_result_t            expected_q [$];
    int unsigned             n_errors;

    function new();
      n_entries = 0;
      capacity  = 32'(bmhq_pkg::CAP_RESET);
      n_errors  = 0;
    endfunction

    function void set_capacity(logic [bmhq_pkg::CAP_W-1:0] cap);
      capacity = 32'(cap);
    endfunction

    function int unsigned pending();
      return $unsigned(expected_q.size());
    endfunction

    // Apply one accepted transaction to the shadow heap and queue its result.
    function void note_request(bmhq_pkg::func_t op, logic signed [KEY_W-1:0] key);
      heap_result_t            r;
      int unsigned             cap;
      int unsigned             i;
      int unsigned             c;
      logic signed [KEY_W-1:0] last;
      cap = (capacity > HEAP_DEPTH) ? HEAP_DEPTH : capacity;
      r.data = '0;
      r.status = bmhq_pkg::ST_OK;
      case (op)
        bmhq_pkg::FUNC_INSERT: begin
          if (n_entries >= cap) begin
            r.status = bmhq_pkg::ST_FULL;
          end else begin
            n_entries++;
            i = n_entries;
            while (i > 1 && keys[i/2] > key) begin
              keys[i] = keys[i/2];
              i = i / 2;
            end
            keys[i] = key;
          end
        end
        bmhq_pkg::FUNC_DELMIN, bmhq_pkg::FUNC_PEEK: begin
          if (n_entries == 0) begin
            r.data = KEY_SENTINEL;
            r.status = bmhq_pkg::ST_EMPTY;
          end else if (op == bmhq_pkg::FUNC_PEEK) begin
            r.data = keys[1];
          end else begin
            r.data = keys[1];
            last = keys[n_entries];
            n_entries--;
            i = 1;
            while (2 * i <= n_entries) begin
              c = 2 * i;
              // ties go to the right child
              if (c != n_entries && keys[c+1] <= keys[c]) c++;
              if (last > keys[c]) begin
                keys[i] = keys[c];
                i = c;
              end else begin
                break;
              end
            end
            keys[i] = last;
          end
        end
        default: begin
          n_entries = 0;
        end
      endcase
      r.count = COUNT_W'(n_entries);
      r.is_full = (n_entries >= cap);
      r.is_empty = (n_entries == 0);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [KEY_W-1:0] data,
                               logic [bmhq_pkg::STAT_W-1:0] status,
                               logic [COUNT_W-1:0] count, logic is_full, logic is_empty);
      heap_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding: data %0d status %0d", data, status);
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $error("data mismatch: expected %0d, actual %0d", e.data, data);
        n_errors++;
      end
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, status);
        n_errors++;
      end
      if (count !== e.count) begin
        $error("count mismatch: expected %0d, actual %0d", e.count, count);
        n_errors++;
      end
      if (is_full !== e.is_full) begin
        $error("is_full mismatch: expected %0d, actual %0d", e.is_full, is_full);
        n_errors++;
      end
      if (is_empty !== e.is_empty) begin
        $error("is_empty mismatch: expected %0d, actual %0d", e.is_empty, is_empty);
        n_errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
// Top-level testbench for binary_min_heap_queue_core: stimulus, monitor and run control.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_W   = heap_queue_scoreboard_pkg::KEY_W;
  localparam int unsigned COUNT_W = heap_queue_scoreboard_pkg::COUNT_W;
  localparam int unsigned STAT_W  = bmhq_pkg::STAT_W;
  localparam int unsigned CAP_W   = bmhq_pkg::CAP_W;
  localparam logic signed [KEY_W-1:0] KEY_SENTINEL = heap_queue_scoreboard_pkg::KEY_SENTINEL;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_func = bmhq_pkg::FUNC_PEEK;
  logic signed [KEY_W-1:0]    in_value = '0;
  logic                       out_valid;
  logic signed [KEY_W-1:0]    out_data;
  logic [STAT_W-1:0]          out_status;
  logic [COUNT_W-1:0]         out_count;
  logic                       out_is_full;
  logic                       out_is_empty;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CAP_W-1:0]           cfg_capacity = bmhq_pkg::CAP_RESET;

  heap_queue_scoreboard_pkg::heap_queue_scoreboard sb = new();

  always #5 clk = ~clk;

  binary_min_heap_queue_core #(
    .DEPTH      (heap_queue_scoreboard_pkg::HEAP_DEPTH),
    .DATA_WIDTH (KEY_W)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_is_full  (out_is_full),
    .out_is_empty (out_is_empty),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity)
  );

  // Results can't be stalled: every strobe is a transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_data, out_status, out_count, out_is_full, out_is_empty);
    end
  end

  function automatic logic signed [KEY_W-1:0] gen_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: k = KEY_SENTINEL;
          1: k = ~KEY_SENTINEL;
          2: k = KEY_SENTINEL + 1;
          3: k = -1;
          4: k = 1;
          default: k = 0;
        endcase
      end
      1, 2, 3, 4, 5: k = $signed($urandom_range(16)) - 8;  // narrow range, many ties
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic send_request(bmhq_pkg::func_t op, logic signed [KEY_W-1:0] key,
                              int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= op;
    in_value <= key;
    do @(posedge clk); while (busy);
    sb.note_request(op, key);
  endtask

  // Capacity is only changed with the queue idle and all results in.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(cap);
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned n_items,
                           int unsigned idle_pct, int unsigned insert_pct);
    bmhq_pkg::func_t op;
    write_capacity(cap);
    repeat (n_items) begin
      if ($urandom_range(99) < insert_pct) begin
        op = bmhq_pkg::FUNC_INSERT;
      end else begin
        case ($urandom_range(19))
          0:             op = bmhq_pkg::FUNC_CLEAR;
          1, 2, 3, 4:    op = bmhq_pkg::FUNC_PEEK;
          default:       op = bmhq_pkg::FUNC_DELMIN;
        endcase
      end
      send_request(op, gen_key(), idle_pct);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, key extremes, duplicates, drain and clear at reset capacity
    send_request(bmhq_pkg::FUNC_PEEK, 0, 0);
    send_request(bmhq_pkg::FUNC_DELMIN, 0, 0);
    send_request(bmhq_pkg::FUNC_INSERT, ~KEY_SENTINEL, 0);
    send_request(bmhq_pkg::FUNC_INSERT, KEY_SENTINEL, 0);
    send_request(bmhq_pkg::FUNC_INSERT, 0, 0);
    send_request(bmhq_pkg::FUNC_INSERT, -1, 0);
    send_request(bmhq_pkg::FUNC_INSERT, -1, 0);
    send_request(bmhq_pkg::FUNC_PEEK, 0, 0);
    repeat (5) send_request(bmhq_pkg::FUNC_DELMIN, 0, 0);
    send_request(bmhq_pkg::FUNC_DELMIN, 0, 0);
    send_request(bmhq_pkg::FUNC_INSERT, 42, 0);
    send_request(bmhq_pkg::FUNC_CLEAR, 0, 0);
    send_request(bmhq_pkg::FUNC_PEEK, 0, 0);

    // zero capacity refuses every insert
    write_capacity(11'd0);
    send_request(bmhq_pkg::FUNC_INSERT, 7, 0);
    // fill a tiny queue, then shrink it below the count
    write_capacity(11'd2);
    send_request(bmhq_pkg::FUNC_INSERT, 3, 0);
    send_request(bmhq_pkg::FUNC_INSERT, 1, 0);
    send_request(bmhq_pkg::FUNC_INSERT, 9, 0);
    write_capacity(11'd1);
    send_request(bmhq_pkg::FUNC_INSERT, 5, 0);
    send_request(bmhq_pkg::FUNC_DELMIN, 0, 0);
    // above depth: clamped
    write_capacity(11'd2047);
    send_request(bmhq_pkg::FUNC_INSERT, 100, 0);

    run_phase(11'd1024, 60, 0, 70);
    run_phase(11'd5, 50, 50, 55);
    run_phase(11'd2047, 60, 0, 55);
    run_phase(11'd1, 40, 15, 50);
    run_phase(11'd0, 20, 0, 50);
    run_phase(11'd1023, 60, 50, 75);
    run_phase(CAP_W'($urandom_range(2, 40)), 60, 15, 50);
    run_phase(11'd1025, 50, 0, 45);
    run_phase(CAP_W'($urandom_range(1, 2047)), 50, 50, 55);

    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.n_errors++;
    end
    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $error("timeout: %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
